/* hdl/rpn_pkg.sv */
`default_nettype none

package rpn_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Word and divider sizes.
  localparam int WORD_W     = 32;
  localparam int DIV_CNT_W  = $clog2(WORD_W);
  localparam int OUT_DATA_W = 40;

  // Token kinds carried on the input tuser.
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_MOD   = 3'd5,
    OP_PRINT = 3'd6
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_RHS,
    ST_GET_RHS,
    ST_POP_LHS,
    ST_GET_LHS,
    ST_DIV,
    ST_DIV_END,
    ST_PUSH,
    ST_DONE
  } state_t;

  // Two's complement magnitude; the most negative word maps to itself.
  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/rpn_stack_evaluator_unit.sv */
// Reverse Polish notation evaluator with an operand stack held in a
// synchronous memory with one write port and one registered read port.
// Input channel: s_axis_tuser carries the token kind (push, add, subtract,
// multiply, divide, modulo, print), s_axis_tdata the number to push.
// Output channel: one item per input item. m_axis_tuser flags a print,
// m_axis_tdata carries the printed word and the underflow, overflow and
// skipped flags.
// One item is worked on at a time. A divide or modulo first pops two
// operands through the registered memory read port, then runs a radix-2
// restoring divider that retires one quotient bit per cycle. A new item
// can be taken in the cycle after the result is loaded.
// A divide by zero ends after its first pop; a modulo whose operands are
// invalid ends after both pops.
// Reset clears the stack pointer, the sequencer and the output valid; the
// memory contents are not cleared, since only written entries are read.
// When the receiver stalls, the finished result waits in the output
// register; the next item may be accepted and worked on meanwhile, and it
// holds in its last state until the output register is free.
`default_nettype none

module rpn_stack_evaluator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] number
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [rpn_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [31:0] value, [32] underflow,
                                                        // [33] overflow, [34] skipped
  output logic             m_axis_tuser   // [0] printed
);

  localparam int W = rpn_pkg::WORD_W;

  rpn_pkg::state_t state, state_next;
  rpn_pkg::op_t    op;

  logic [rpn_pkg::SP_W-1:0]   sp;
  logic [W-1:0]               number;
  logic [W-1:0]               rhs;
  logic [W-1:0]               result;
  logic [W-1:0]               value;
  logic                       printed;
  logic                       underflow;
  logic                       overflow;
  logic                       skipped;
  logic                       pop_hit;
  logic                       neg;

  // Divider registers.
  logic [W-1:0]                  div_rem;
  logic [W-1:0]                  div_quo;
  logic [W-1:0]                  div_den;
  logic [rpn_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [W:0]                    div_shift;
  logic [W+1:0]                  div_diff;

  // Stack memory and its ports.
  logic [W-1:0] stack_mem [rpn_pkg::STACK_DEPTH];
  logic [W-1:0] rdata;
  logic         mem_re;
  logic         mem_we;
  logic [rpn_pkg::ADDR_W-1:0] raddr;
  logic [rpn_pkg::ADDR_W-1:0] waddr;

  logic         accept;
  logic         out_free;
  logic         sp_nonzero;
  logic         sp_room;
  logic [W-1:0] pop_val;
  logic [rpn_pkg::ADDR_W-1:0] sp_dec;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign sp_nonzero = (sp != '0);
  assign sp_room    = (sp < rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH));
  assign pop_val    = pop_hit ? rdata : '0;
  assign sp_dec     = rpn_pkg::ADDR_W'(sp - rpn_pkg::SP_W'(1));
  assign raddr      = sp_dec;
  assign waddr      = sp[rpn_pkg::ADDR_W-1:0];

  // One restoring divider step.
  assign div_shift = {div_rem, div_quo[W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_den};

  // Sequencer: next state and memory strobes.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    case (state)
      rpn_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid) begin
          case (rpn_pkg::op_t'(s_axis_tuser))
            rpn_pkg::OP_PUSH:  state_next = rpn_pkg::ST_PUSH;
            rpn_pkg::OP_ADD,
            rpn_pkg::OP_SUB,
            rpn_pkg::OP_MUL,
            rpn_pkg::OP_DIV,
            rpn_pkg::OP_MOD,
            rpn_pkg::OP_PRINT: state_next = rpn_pkg::ST_POP_RHS;
            default:           state_next = rpn_pkg::ST_DONE;
          endcase
        end
      end
      rpn_pkg::ST_POP_RHS: begin
        mem_re     = sp_nonzero;
        state_next = rpn_pkg::ST_GET_RHS;
      end
      rpn_pkg::ST_GET_RHS: begin
        if (op == rpn_pkg::OP_PRINT) begin
          state_next = rpn_pkg::ST_DONE;
        end else if (op == rpn_pkg::OP_DIV && pop_val == '0) begin
          state_next = rpn_pkg::ST_DONE;
        end else begin
          state_next = rpn_pkg::ST_POP_LHS;
        end
      end
      rpn_pkg::ST_POP_LHS: begin
        mem_re     = sp_nonzero;
        state_next = rpn_pkg::ST_GET_LHS;
      end
      rpn_pkg::ST_GET_LHS: begin
        case (op)
          rpn_pkg::OP_DIV: state_next = rpn_pkg::ST_DIV;
          rpn_pkg::OP_MOD: begin
            if (pop_val[W-1] || rhs == '0) begin
              state_next = rpn_pkg::ST_DONE;
            end else begin
              state_next = rpn_pkg::ST_DIV;
            end
          end
          default: state_next = rpn_pkg::ST_PUSH;
        endcase
      end
      rpn_pkg::ST_DIV: begin
        if (div_cnt == '1) begin
          state_next = rpn_pkg::ST_DIV_END;
        end
      end
      rpn_pkg::ST_DIV_END: begin
        state_next = rpn_pkg::ST_PUSH;
      end
      rpn_pkg::ST_PUSH: begin
        mem_we     = sp_room;
        state_next = rpn_pkg::ST_DONE;
      end
      rpn_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = rpn_pkg::ST_IDLE;
        end
      end
      default: state_next = rpn_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[waddr] <= result;
    end
    if (mem_re) begin
      rdata <= stack_mem[raddr];
    end
  end

  // Stack pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if ((state == rpn_pkg::ST_POP_RHS || state == rpn_pkg::ST_POP_LHS)
                 && sp_nonzero) begin
      sp <= sp - rpn_pkg::SP_W'(1);
    end else if (mem_we) begin
      sp <= sp + rpn_pkg::SP_W'(1);
    end
  end

  // Datapath: operands, flags, arithmetic and the divider.
  always_ff @(posedge clk) begin
    case (state)
      rpn_pkg::ST_IDLE: begin
        if (accept) begin
          op        <= rpn_pkg::op_t'(s_axis_tuser);
          number    <= s_axis_tdata;
          result    <= s_axis_tdata;
          value     <= '0;
          printed   <= 1'b0;
          underflow <= 1'b0;
          overflow  <= 1'b0;
          skipped   <= 1'b0;
        end
      end
      rpn_pkg::ST_POP_RHS, rpn_pkg::ST_POP_LHS: begin
        pop_hit <= sp_nonzero;
        if (!sp_nonzero) begin
          underflow <= 1'b1;
        end
      end
      rpn_pkg::ST_GET_RHS: begin
        rhs <= pop_val;
        if (op == rpn_pkg::OP_PRINT) begin
          value   <= pop_val;
          printed <= 1'b1;
        end else if (op == rpn_pkg::OP_DIV && pop_val == '0) begin
          skipped <= 1'b1;
        end
      end
      rpn_pkg::ST_GET_LHS: begin
        div_cnt <= '0;
        div_rem <= '0;
        div_den <= rpn_pkg::magnitude(rhs);
        neg     <= pop_val[W-1] ^ rhs[W-1];
        case (op)
          rpn_pkg::OP_ADD: result <= pop_val + rhs;
          rpn_pkg::OP_SUB: result <= pop_val - rhs;
          rpn_pkg::OP_MUL: result <= W'(pop_val * rhs);
          rpn_pkg::OP_DIV: div_quo <= rpn_pkg::magnitude(pop_val);
          rpn_pkg::OP_MOD: begin
            div_quo <= pop_val;
            if (pop_val[W-1] || rhs == '0) begin
              skipped <= 1'b1;
            end
          end
          default: result <= number;
        endcase
      end
      rpn_pkg::ST_DIV: begin
        div_cnt <= div_cnt + rpn_pkg::DIV_CNT_W'(1);
        if (!div_diff[W+1]) begin
          div_rem <= div_diff[W-1:0];
          div_quo <= {div_quo[W-2:0], 1'b1};
        end else begin
          div_rem <= div_shift[W-1:0];
          div_quo <= {div_quo[W-2:0], 1'b0};
        end
      end
      rpn_pkg::ST_DIV_END: begin
        if (op == rpn_pkg::OP_MOD) begin
          result <= div_rem;
        end else begin
          result <= neg ? (~div_quo + W'(1)) : div_quo;
        end
      end
      rpn_pkg::ST_PUSH: begin
        if (!sp_room) begin
          overflow <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == rpn_pkg::ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rpn_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= {5'b00000, skipped, overflow, underflow, value};
      m_axis_tuser <= printed;
    end
  end

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS    = 550;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_WAIT = 60;

  // Fields of one result item.
  typedef struct packed {
    logic        printed;
    logic [31:0] value;
    logic        underflow;
    logic        overflow;
    logic        skipped;
  } token_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    rpn_pkg::op_t  op;
    logic [31:0]   num;
    logic          typed;
    token_result_t want;
  } token_row_t;

  localparam token_result_t NO_CHECK = '0;

  logic                           clk;
  logic                           rst;
  logic                           s_valid;
  rpn_pkg::op_t                   s_op;
  logic [31:0]                    s_num;
  logic                           s_axis_tready;
  logic                           m_axis_tvalid;
  logic                           m_ready;
  logic [rpn_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;

  // Shared between the driver and the monitors.
  bit            quiet;
  bit            row_typed;
  token_result_t row_want;
  int            sent;
  int            errors;
  int            results_seen;
  int            stall_cycles;

  // Predicted stack contents and depth.
  logic [31:0]   shadow_stack [rpn_pkg::STACK_DEPTH];
  int unsigned   shadow_depth;
  bit            pop_underflow;
  bit            push_overflow;

  token_result_t token_results_q [$];

  // Directed tokens: extremes, every operator and each corner case.
  token_row_t directed_rows [25] = '{
    // Print and add on an empty stack both underflow.
    '{rpn_pkg::OP_PRINT, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 1'b1, 1'b0, 1'b0}},
    '{rpn_pkg::OP_ADD,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0}},
    '{rpn_pkg::OP_PRINT, 32'h1234_5678, 1'b1, '{1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    // Add wraps past the most positive word.
    '{rpn_pkg::OP_PUSH,  32'h7FFF_FFFF, 1'b1, NO_CHECK},
    '{rpn_pkg::OP_PUSH,  32'h0000_0001, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_ADD,   32'h0000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PRINT, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 1'b0, 1'b0}},
    // Most negative word divided by minus one.
    '{rpn_pkg::OP_PUSH,  32'h8000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PUSH,  32'hFFFF_FFFF, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_DIV,   32'h0000_0000, 1'b0, NO_CHECK},
    // Divide by zero keeps the dividend on the stack.
    '{rpn_pkg::OP_PUSH,  32'h0000_0005, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PUSH,  32'h0000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_DIV,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
    // Modulo by zero drops both operands.
    '{rpn_pkg::OP_PUSH,  32'h0000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_MOD,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
    // Modulo with a negative dividend is skipped.
    '{rpn_pkg::OP_PUSH,  32'h0000_0007, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_MOD,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
    // Multiply, subtract and modulo with negative operands.
    '{rpn_pkg::OP_PUSH,  32'hFFFF_FFF9, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PUSH,  32'hFFFF_FFFD, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_MUL,   32'h0000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PUSH,  32'hFFFF_FFFC, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_SUB,   32'h0000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PUSH,  32'hFFFF_FFF9, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_MOD,   32'h0000_0000, 1'b0, NO_CHECK},
    '{rpn_pkg::OP_PRINT, 32'h0000_0000, 1'b0, NO_CHECK}
  };

  rpn_stack_evaluator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_num),
    .s_axis_tuser  (s_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pop from the predicted stack; an empty stack yields zero.
  function automatic logic [31:0] shadow_pop();
    if (shadow_depth > 0) begin
      shadow_depth--;
      return shadow_stack[shadow_depth];
    end
    pop_underflow = 1'b1;
    return 32'h0;
  endfunction

  // Push onto the predicted stack; a full stack drops the word.
  function automatic void shadow_push(input logic [31:0] w);
    if (shadow_depth < rpn_pkg::STACK_DEPTH) begin
      shadow_stack[shadow_depth] = w;
      shadow_depth++;
    end else begin
      push_overflow = 1'b1;
    end
  endfunction

  function automatic logic [31:0] abs_word(input logic [31:0] w);
    return w[31] ? (32'h0 - w) : w;
  endfunction

  // Work out the result of one token and update the predicted stack.
  function automatic token_result_t eval_token(input rpn_pkg::op_t op,
                                               input logic [31:0] num);
    token_result_t r;
    logic [31:0]   lhs;
    logic [31:0]   rhs;
    logic [31:0]   quo;
    r = '0;
    pop_underflow = 1'b0;
    push_overflow = 1'b0;
    case (op)
      rpn_pkg::OP_PUSH: shadow_push(num);
      rpn_pkg::OP_ADD: begin
        rhs = shadow_pop();
        lhs = shadow_pop();
        shadow_push(lhs + rhs);
      end
      rpn_pkg::OP_SUB: begin
        rhs = shadow_pop();
        lhs = shadow_pop();
        shadow_push(lhs - rhs);
      end
      rpn_pkg::OP_MUL: begin
        rhs = shadow_pop();
        lhs = shadow_pop();
        shadow_push(lhs * rhs);
      end
      rpn_pkg::OP_DIV: begin
        rhs = shadow_pop();
        if (rhs != 32'h0) begin
          lhs = shadow_pop();
          quo = abs_word(lhs) / abs_word(rhs);
          shadow_push((lhs[31] ^ rhs[31]) ? (32'h0 - quo) : quo);
        end else begin
          r.skipped = 1'b1;
        end
      end
      rpn_pkg::OP_MOD: begin
        rhs = shadow_pop();
        lhs = shadow_pop();
        if (!lhs[31] && rhs != 32'h0) begin
          shadow_push(lhs % abs_word(rhs));
        end else begin
          r.skipped = 1'b1;
        end
      end
      rpn_pkg::OP_PRINT: begin
        r.value   = shadow_pop();
        r.printed = 1'b1;
      end
      default: ;
    endcase
    r.underflow = pop_underflow;
    r.overflow  = push_overflow;
    return r;
  endfunction

  // Operand values weighted toward the corner cases.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'($urandom_range(0, 40) - 20);
      7:       return 32'h0000_0001;
      8, 9:    return 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_err(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
  endtask

  // Offer one item at a falling edge and hold it until it is taken.
  task automatic send_token(input rpn_pkg::op_t op, input logic [31:0] num,
                            input bit typed, input token_result_t want);
    @(negedge clk);
    quiet = (sent >= 150 && sent < 260);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid   <= 1'b1;
    s_op      <= op;
    s_num     <= num;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Receiver side: random back pressure except in the quiet stretch.
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk);
      m_ready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  // Check each result item, then predict for each accepted input item.
  always @(posedge clk) begin : monitor
    token_result_t got;
    token_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_ready) begin
        got.printed   = m_axis_tuser;
        got.value     = m_axis_tdata[31:0];
        got.underflow = m_axis_tdata[32];
        got.overflow  = m_axis_tdata[33];
        got.skipped   = m_axis_tdata[34];
        if (token_results_q.size() == 0) begin
          report_err($sformatf("unexpected item, value %h", got.value));
        end else begin
          want = token_results_q.pop_front();
          if (got.printed !== want.printed)
            report_err($sformatf("printed %b, want %b", got.printed, want.printed));
          if (got.value !== want.value)
            report_err($sformatf("value %h, want %h", got.value, want.value));
          if (got.underflow !== want.underflow)
            report_err($sformatf("underflow %b, want %b", got.underflow, want.underflow));
          if (got.overflow !== want.overflow)
            report_err($sformatf("overflow %b, want %b", got.overflow, want.overflow));
          if (got.skipped !== want.skipped)
            report_err($sformatf("skipped %b, want %b", got.skipped, want.skipped));
        end
        results_seen++;
      end
      if (s_valid && s_axis_tready) begin
        want = eval_token(s_op, s_num);
        if (row_typed) want = row_want;
        token_results_q.push_back(want);
      end
    end
  end

  // End the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random token streams.
  initial begin
    int           n;
    int           roll;
    bit           filled;
    bit           drained;
    rpn_pkg::op_t kind;
    rst          = 1'b1;
    s_valid      = 1'b0;
    s_op         = rpn_pkg::OP_PUSH;
    s_num        = 32'h0;
    quiet        = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    sent         = 0;
    errors       = 0;
    results_seen = 0;
    stall_cycles = 0;
    shadow_depth = 0;
    filled       = 1'b0;
    drained      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_token(directed_rows[i].op, directed_rows[i].num, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    while (sent < N_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (!filled && sent >= 200) begin
        // Fill the stack past its depth so pushes overflow.
        repeat (rpn_pkg::STACK_DEPTH + 4)
          send_token(rpn_pkg::OP_PUSH, pick_word(), 1'b0, NO_CHECK);
        filled = 1'b1;
      end else if (filled && !drained) begin
        // Empty it again, mostly by printing, until pops underflow.
        repeat (rpn_pkg::STACK_DEPTH + 12) begin
          kind = ($urandom_range(0, 99) < 85) ? rpn_pkg::OP_PRINT
                                              : rpn_pkg::op_t'($urandom_range(1, 5));
          send_token(kind, $urandom, 1'b0, NO_CHECK);
        end
        drained = 1'b1;
      end else if (roll < 75) begin
        // A well-formed expression with random operands and operators.
        n = $urandom_range(1, 4);
        repeat (n) send_token(rpn_pkg::OP_PUSH, pick_word(), 1'b0, NO_CHECK);
        repeat (n - 1)
          send_token(rpn_pkg::op_t'($urandom_range(1, 5)), $urandom, 1'b0, NO_CHECK);
        if ($urandom_range(0, 99) < 60)
          send_token(rpn_pkg::OP_PRINT, $urandom, 1'b0, NO_CHECK);
      end else begin
        // Lone random token.
        send_token(rpn_pkg::op_t'($urandom_range(0, 6)), pick_word(), 1'b0, NO_CHECK);
      end
    end

    @(negedge clk);
    s_valid <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* rpn_stack_evaluator_unit.f */
hdl/rpn_pkg.sv
hdl/rpn_stack_evaluator_unit.sv
dv/testbench.sv
